>>> design/etf_pkg.sv
package etf_pkg;

	localparam int MAX_ITERATIONS = 256;
	localparam int IMAGE_WIDTH    = 1024;
	localparam int IMAGE_HEIGHT   = 1024;
	localparam int FRAC_BITS      = 28;

	localparam int DATA_W  = 32;
	localparam int LIMIT_W = 31;
	localparam int MODE_W  = 2;
	localparam int PIX_W   = 10;
	localparam int OUT_W   = 9;
	localparam int IDX_W   = 3;
	localparam int CNT_W   = $clog2(MAX_ITERATIONS + 1);
	localparam int OUT_MAX = (1 << OUT_W) - 1;

	localparam logic [PIX_W-1:0] X_LAST = PIX_W'(IMAGE_WIDTH - 1);
	localparam logic [PIX_W-1:0] Y_LAST = PIX_W'(IMAGE_HEIGHT - 1);

	typedef logic signed [DATA_W-1:0]   fx_t;
	typedef logic signed [2*DATA_W-1:0] prod_t;

	localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Fractal modes.
	localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_REAL_ORIGIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_IMAG_ORIGIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_REAL_STEP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_IMAG_STEP   = 3'd4;
	localparam logic [IDX_W-1:0] REG_JULIA_REAL  = 3'd5;
	localparam logic [IDX_W-1:0] REG_JULIA_IMAG  = 3'd6;
	localparam logic [IDX_W-1:0] REG_ESC_LIMIT   = 3'd7;

	function automatic fx_t sat_fx(input prod_t v);
		fx_t r;
		if (v > prod_t'(FX_MAX)) begin
			r = FX_MAX;
		end else if (v < prod_t'(FX_MIN)) begin
			r = FX_MIN;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic fx_t add_sat(input fx_t a, input fx_t b);
		return sat_fx(prod_t'(a) + prod_t'(b));
	endfunction

	function automatic fx_t sub_sat(input fx_t a, input fx_t b);
		return sat_fx(prod_t'(a) - prod_t'(b));
	endfunction

	function automatic logic [OUT_W-1:0] count_out(input logic [CNT_W-1:0] n);
		logic [OUT_W-1:0] r;
		if (32'(n) > OUT_MAX) begin
			r = '1;
		end else begin
			r = OUT_W'(n);
		end
		return r;
	endfunction

endpackage

>>> design/escape_time_fractal_iterator_unit.sv
// Escape-time fractal iterator (Mandelbrot, Julia, Burning Ship).
// Input channel (in_valid/in_ready) carries one pixel beat: pixel_x, pixel_y.
// Output channel (out_valid/out_ready) carries one beat per pixel with the
// iteration count. The configuration port (cfg_we, cfg_index, cfg_wdata)
// writes one register per cycle and must only be used while the block is idle.
// One signed 32x32 multiplier is shared by a small sequencer: states MAPX
// and MAPY map the pixel onto the complex plane, INIT sets up z and c, and
// each iteration then steps through SQR, SQI, CRS and UPD (zr*zr, zi*zi,
// zr*zi with the escape test, update). Unused mode 3 goes from INIT straight
// to the done state without iterating. A pixel runs at most 256 iterations
// through the multiplier, and a new pixel is taken only once it has finished.
// in_ready is high whenever the sequencer is idle, even while a result beat
// still waits in the output register. If the receiver stalls, a finished
// pixel holds in the done state until the output register frees up.
// Reset clears the sequencer and the output valid and restores the register
// defaults (Mandelbrot, origin -2.0 + 2.0i, steps 2^-8 and -2^-8, limit 4.0).
module escape_time_fractal_iterator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [etf_pkg::PIX_W-1:0]        pixel_x,
	input  logic [etf_pkg::PIX_W-1:0]        pixel_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [etf_pkg::OUT_W-1:0]        iteration_count,
	input  logic                             cfg_we,
	input  logic [etf_pkg::IDX_W-1:0]        cfg_index,
	input  logic [etf_pkg::DATA_W-1:0]       cfg_wdata
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAPX = 4'd1;
	localparam logic [3:0] S_MAPY = 4'd2;
	localparam logic [3:0] S_INIT = 4'd3;
	localparam logic [3:0] S_SQR  = 4'd4;
	localparam logic [3:0] S_SQI  = 4'd5;
	localparam logic [3:0] S_CRS  = 4'd6;
	localparam logic [3:0] S_UPD  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;

	logic [etf_pkg::MODE_W-1:0]  mode_q;
	etf_pkg::fx_t                real_origin_q, imag_origin_q;
	etf_pkg::fx_t                real_step_q, imag_step_q;
	etf_pkg::fx_t                julia_re_q, julia_im_q;
	logic [etf_pkg::LIMIT_W-1:0] limit_q;

	logic [etf_pkg::PIX_W-1:0] px_q, py_q;
	etf_pkg::fx_t              pr_q, zr_q, zi_q, cr_q, ci_q, r2_q, i2_q;
	etf_pkg::prod_t            prod_q;
	logic [etf_pkg::CNT_W-1:0] n_q;
	logic                      out_valid_q;
	logic [etf_pkg::OUT_W-1:0] count_q;

	etf_pkg::fx_t   mul_a, mul_b;
	etf_pkg::prod_t prod;
	etf_pkg::fx_t   map_term, pi_val, sq_term, mag, cross_raw, cross_term, nr;
	logic           escape;
	logic           out_free;

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;
	assign out_free        = !out_valid_q || out_ready;

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = zr_q;
		mul_b = zr_q;
		case (state_q)
			S_MAPX: begin
				mul_a = signed'({{(etf_pkg::DATA_W-etf_pkg::PIX_W){1'b0}}, px_q});
				mul_b = real_step_q;
			end
			S_MAPY: begin
				mul_a = signed'({{(etf_pkg::DATA_W-etf_pkg::PIX_W){1'b0}}, py_q});
				mul_b = imag_step_q;
			end
			S_SQI: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			S_CRS: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		map_term  = etf_pkg::sat_fx(prod_q);
		pi_val    = etf_pkg::add_sat(imag_origin_q, map_term);
		// Arithmetic shifts of a signed value round toward minus infinity.
		sq_term   = etf_pkg::sat_fx(prod_q >>> etf_pkg::FRAC_BITS);
		mag       = etf_pkg::add_sat(r2_q, sq_term);
		escape    = (32'(n_q) >= etf_pkg::MAX_ITERATIONS) ||
		            (mag > signed'({1'b0, limit_q}));
		cross_raw = etf_pkg::sat_fx(prod_q >>> (etf_pkg::FRAC_BITS - 1));
		cross_term = cross_raw;
		if (mode_q == etf_pkg::MODE_SHIP && cross_raw < 0) begin
			cross_term = (cross_raw == etf_pkg::FX_MIN) ? etf_pkg::FX_MAX : -cross_raw;
		end
		nr        = etf_pkg::add_sat(etf_pkg::sub_sat(r2_q, i2_q), cr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= etf_pkg::MODE_MANDEL;
			real_origin_q <= -32'sd536870912;
			imag_origin_q <= 32'sd536870912;
			real_step_q   <= 32'sd1048576;
			imag_step_q   <= -32'sd1048576;
			julia_re_q    <= '0;
			julia_im_q    <= '0;
			limit_q       <= 31'd1073741824;
		end else if (cfg_we) begin
			case (cfg_index)
				etf_pkg::REG_MODE:        mode_q        <= cfg_wdata[etf_pkg::MODE_W-1:0];
				etf_pkg::REG_REAL_ORIGIN: real_origin_q <= signed'(cfg_wdata);
				etf_pkg::REG_IMAG_ORIGIN: imag_origin_q <= signed'(cfg_wdata);
				etf_pkg::REG_REAL_STEP:   real_step_q   <= signed'(cfg_wdata);
				etf_pkg::REG_IMAG_STEP:   imag_step_q   <= signed'(cfg_wdata);
				etf_pkg::REG_JULIA_REAL:  julia_re_q    <= signed'(cfg_wdata);
				etf_pkg::REG_JULIA_IMAG:  julia_im_q    <= signed'(cfg_wdata);
				etf_pkg::REG_ESC_LIMIT:   limit_q       <= cfg_wdata[etf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MAPX;
						n_q     <= '0;
					end
				end
				S_MAPX: state_q <= S_MAPY;
				S_MAPY: state_q <= S_INIT;
				S_INIT: begin
					state_q <= (mode_q == etf_pkg::MODE_MANDEL || mode_q == etf_pkg::MODE_JULIA
					            || mode_q == etf_pkg::MODE_SHIP) ? S_SQR : S_DONE;
				end
				S_SQR: state_q <= S_SQI;
				S_SQI: state_q <= S_CRS;
				S_CRS: state_q <= escape ? S_DONE : S_UPD;
				S_UPD: begin
					state_q <= S_SQR;
					n_q     <= n_q + 1'b1;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= prod;
		case (state_q)
			S_IDLE: begin
				px_q <= (pixel_x > etf_pkg::X_LAST) ? etf_pkg::X_LAST : pixel_x;
				py_q <= (pixel_y > etf_pkg::Y_LAST) ? etf_pkg::Y_LAST : pixel_y;
			end
			S_MAPY: pr_q <= etf_pkg::add_sat(real_origin_q, map_term);
			S_INIT: begin
				if (mode_q == etf_pkg::MODE_JULIA) begin
					zr_q <= pr_q;
					zi_q <= pi_val;
					cr_q <= julia_re_q;
					ci_q <= julia_im_q;
				end else begin
					zr_q <= '0;
					zi_q <= '0;
					cr_q <= pr_q;
					ci_q <= pi_val;
				end
			end
			S_SQI: r2_q <= sq_term;
			S_CRS: i2_q <= sq_term;
			S_UPD: begin
				zr_q <= nr;
				zi_q <= etf_pkg::add_sat(cross_term, ci_q);
			end
			S_DONE: begin
				if (out_free) begin
					count_q <= etf_pkg::count_out(n_q);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= etf_pkg::MAX_ITERATIONS)
		else $error("iteration counter passed the limit");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MAPX)
		else $error("accepted pixel did not start mapping");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("finished pixel left done while output was stalled");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> 32'(iteration_count) <= etf_pkg::MAX_ITERATIONS)
		else $error("reported count beyond the iteration limit");
`endif

endmodule
